/* hw/rtl/mpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mpm_pkg;

    // Width of the pattern number carried in a result.
    localparam int ID_W = 8;
    // Width of the start position carried in a result.
    localparam int OUT_POS_W = 32;

    // Input item kinds.
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_SCAN  = 2'd2;

    // Result status codes.
    localparam logic STATUS_MATCH = 1'b0;
    localparam logic STATUS_DROP  = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LD_GOTO,
        ST_LD_LINK,
        ST_LD_VER,
        ST_LD_END,
        ST_LD_DROP,
        ST_SC_APPEND,
        ST_SC_START,
        ST_SC_RDBUF,
        ST_SC_GOTO,
        ST_SC_LINK,
        ST_SC_VER,
        ST_SC_TAG,
        ST_SC_PUSH,
        ST_SC_FLUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_clear;
        logic set_drop;
        logic ld_step;
        logic ld_create;
        logic ld_finish_ok;
        logic ld_finish_drop;
        logic sc_append;
        logic walk_init;
        logic rd_buf;
        logic rd_goto;
        logic rd_link;
        logic rd_tag;
        logic sc_step;
        logic sc_hit;
        logic next_start;
        logic push;
        logic flush;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       pend;
        logic       dropping;
        logic       depth_full;
        logic       nodes_full;
        logic       pats_full;
        logic       c_ok;
        logic       j_last;
        logic       i_done;
        logic       term;
        logic       hold_valid;
        logic       out_free;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/mpm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mpm_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  mpm_pkg::status_t st,
    output mpm_pkg::cmd_t    cmd
);

    mpm_pkg::state_t state_reg;
    mpm_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpm_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = mpm_pkg::ST_DISPATCH;
            end
            mpm_pkg::ST_DISPATCH: begin
                case (st.func)
                    mpm_pkg::FUNC_LOAD: begin
                        if (st.dropping || st.depth_full) begin
                            state_next = mpm_pkg::ST_LD_END;
                        end else begin
                            state_next = mpm_pkg::ST_LD_GOTO;
                        end
                    end
                    mpm_pkg::FUNC_SCAN: state_next = mpm_pkg::ST_SC_APPEND;
                    default:            state_next = mpm_pkg::ST_IDLE;
                endcase
            end
            mpm_pkg::ST_LD_GOTO: state_next = mpm_pkg::ST_LD_LINK;
            mpm_pkg::ST_LD_LINK: state_next = mpm_pkg::ST_LD_VER;
            mpm_pkg::ST_LD_VER:  state_next = mpm_pkg::ST_LD_END;
            mpm_pkg::ST_LD_END: begin
                if (!st.pend) begin
                    state_next = mpm_pkg::ST_IDLE;
                end else if (st.dropping || st.pats_full) begin
                    state_next = mpm_pkg::ST_LD_DROP;
                end else begin
                    state_next = mpm_pkg::ST_IDLE;
                end
            end
            mpm_pkg::ST_LD_DROP: begin
                if (st.out_free) state_next = mpm_pkg::ST_IDLE;
            end
            mpm_pkg::ST_SC_APPEND: state_next = mpm_pkg::ST_SC_START;
            mpm_pkg::ST_SC_START: begin
                if (st.i_done) begin
                    state_next = mpm_pkg::ST_SC_FLUSH;
                end else begin
                    state_next = mpm_pkg::ST_SC_RDBUF;
                end
            end
            mpm_pkg::ST_SC_RDBUF: state_next = mpm_pkg::ST_SC_GOTO;
            mpm_pkg::ST_SC_GOTO:  state_next = mpm_pkg::ST_SC_LINK;
            mpm_pkg::ST_SC_LINK:  state_next = mpm_pkg::ST_SC_VER;
            mpm_pkg::ST_SC_VER: begin
                // A goto entry that was never written must fall to the miss path.
                if (st.c_ok) begin
                    if (st.j_last) begin
                        state_next = mpm_pkg::ST_SC_TAG;
                    end else begin
                        state_next = mpm_pkg::ST_SC_RDBUF;
                    end
                end else begin
                    state_next = mpm_pkg::ST_SC_START;
                end
            end
            mpm_pkg::ST_SC_TAG: begin
                if (st.term) begin
                    state_next = mpm_pkg::ST_SC_PUSH;
                end else begin
                    state_next = mpm_pkg::ST_SC_START;
                end
            end
            mpm_pkg::ST_SC_PUSH: begin
                if (!st.hold_valid || st.out_free) state_next = mpm_pkg::ST_SC_START;
            end
            mpm_pkg::ST_SC_FLUSH: begin
                if (!st.hold_valid || st.out_free) state_next = mpm_pkg::ST_IDLE;
            end
            default: state_next = mpm_pkg::ST_IDLE;
        endcase
    end

    // Output logic: one command group per state.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            mpm_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            mpm_pkg::ST_DISPATCH: begin
                if (st.func == mpm_pkg::FUNC_RESET) cmd.scan_clear = 1'b1;
                if (st.func == mpm_pkg::FUNC_LOAD && !st.dropping && st.depth_full) begin
                    cmd.set_drop = 1'b1;
                end
            end
            mpm_pkg::ST_LD_GOTO: cmd.rd_goto = 1'b1;
            mpm_pkg::ST_LD_LINK: cmd.rd_link = 1'b1;
            mpm_pkg::ST_LD_VER: begin
                if (st.c_ok) begin
                    cmd.ld_step = 1'b1;
                end else if (st.nodes_full) begin
                    cmd.set_drop = 1'b1;
                end else begin
                    cmd.ld_create = 1'b1;
                end
            end
            mpm_pkg::ST_LD_END: begin
                if (st.pend && !st.dropping && !st.pats_full) cmd.ld_finish_ok = 1'b1;
            end
            mpm_pkg::ST_LD_DROP: cmd.ld_finish_drop = st.out_free;
            mpm_pkg::ST_SC_APPEND: cmd.sc_append = 1'b1;
            mpm_pkg::ST_SC_START:  cmd.walk_init = !st.i_done;
            mpm_pkg::ST_SC_RDBUF:  cmd.rd_buf = 1'b1;
            mpm_pkg::ST_SC_GOTO:   cmd.rd_goto = 1'b1;
            mpm_pkg::ST_SC_LINK:   cmd.rd_link = 1'b1;
            mpm_pkg::ST_SC_VER: begin
                if (st.c_ok) begin
                    if (st.j_last) begin
                        cmd.sc_hit = 1'b1;
                        cmd.rd_tag = 1'b1;
                    end else begin
                        cmd.sc_step = 1'b1;
                    end
                end else begin
                    cmd.next_start = 1'b1;
                end
            end
            mpm_pkg::ST_SC_TAG: cmd.next_start = !st.term;
            mpm_pkg::ST_SC_PUSH: begin
                if (!st.hold_valid || st.out_free) begin
                    cmd.push       = 1'b1;
                    cmd.next_start = 1'b1;
                end
            end
            mpm_pkg::ST_SC_FLUSH: begin
                if (!st.hold_valid || st.out_free) begin
                    cmd.flush  = 1'b1;
                    cmd.commit = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/mpm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module mpm_datapath #(
    parameter int MAX_NODES       = 1024,
    parameter int MAX_PATTERNS    = 256,
    parameter int MAX_PATTERN_LEN = 64,
    parameter int POS_BITS        = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire  [7:0]           s_tdata,
    input  wire  [1:0]           s_tuser,
    input  wire                  s_tlast,
    output logic [39:0]          m_tdata,
    output logic [0:0]           m_tuser,
    output logic                 m_tvalid,
    output logic                 m_tlast,
    input  wire                  m_tready,
    input  mpm_pkg::cmd_t        cmd,
    output mpm_pkg::status_t     st
);

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NU_W   = $clog2(MAX_NODES + 1);
    localparam int PAT_W  = $clog2(MAX_PATTERNS + 1);
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int BUF_AW = $clog2(MAX_PATTERN_LEN + 2);
    localparam int BUF_D  = 1 << BUF_AW;
    localparam int GOTO_D = MAX_NODES * 256;
    localparam int IdW    = mpm_pkg::ID_W;
    localparam int OposW  = mpm_pkg::OUT_POS_W;

    // Latched input item.
    logic [1:0]          func_reg;
    logic [7:0]          sym_reg;
    logic                pend_reg;

    // Load side.
    logic [NODE_W-1:0]   cursor_reg;
    logic [LEN_W-1:0]    ldepth_reg;
    logic [NU_W-1:0]     nodes_reg;
    logic [PAT_W-1:0]    pats_reg;
    logic                drop_reg;

    // Scan side: the text suffix that names the scan node lives in a ring buffer.
    logic [BUF_AW-1:0]   base_reg;
    logic [BUF_AW-1:0]   slen_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [BUF_AW-1:0]   i_reg;
    logic [BUF_AW-1:0]   j_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [7:0]          byte_reg;
    logic [NODE_W-1:0]   c_reg;
    logic                found_reg;
    logic [BUF_AW-1:0]   nbase_reg;
    logic [BUF_AW-1:0]   nlen_reg;

    // Held result and output register.
    logic                hold_valid_reg;
    logic [IdW-1:0]      hold_id_reg;
    logic [OposW-1:0]    hold_pos_reg;
    logic                out_valid_reg;
    logic                out_status_reg;
    logic [IdW-1:0]      out_id_reg;
    logic [OposW-1:0]    out_pos_reg;
    logic                out_last_reg;

    // Memories.
    logic [NODE_W-1:0]   goto_mem [GOTO_D];
    logic [NODE_W+7:0]   link_mem [MAX_NODES];
    logic [IdW:0]        tag_mem  [MAX_NODES];
    logic [7:0]          buf_mem  [BUF_D];

    logic [NODE_W-1:0]   goto_rdata;
    logic [NODE_W+7:0]   link_rdata;
    logic [IdW:0]        tag_rdata;
    logic [7:0]          buf_rdata;

    logic                is_scan;
    logic [NODE_W+7:0]   goto_raddr;
    logic [NODE_W-1:0]   new_node;
    logic [NODE_W-1:0]   ref_node;
    logic [7:0]          ref_byte;
    logic                out_free;
    logic [BUF_AW-1:0]   match_len;
    logic [POS_BITS-1:0] match_pos;

    assign is_scan    = (func_reg == mpm_pkg::FUNC_SCAN);
    assign goto_raddr = is_scan ? {node_reg, buf_rdata} : {cursor_reg, sym_reg};
    assign new_node   = nodes_reg[NODE_W-1:0];
    assign ref_node   = is_scan ? node_reg : cursor_reg;
    assign ref_byte   = is_scan ? byte_reg : sym_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign match_len  = slen_reg - i_reg;
    assign match_pos  = pos_reg - POS_BITS'(match_len) + POS_BITS'(1);

    // Goto table: stale entries are screened by the node record check below.
    always_ff @(posedge aclk) begin
        if (cmd.ld_create) goto_mem[{cursor_reg, sym_reg}] <= new_node;
        if (cmd.rd_goto) goto_rdata <= goto_mem[goto_raddr];
    end

    // Node records: parent and edge byte.
    always_ff @(posedge aclk) begin
        if (cmd.ld_create) link_mem[new_node] <= {cursor_reg, sym_reg};
        if (cmd.rd_link) link_rdata <= link_mem[goto_rdata];
    end

    // Node tags: terminal mark and pattern number.
    always_ff @(posedge aclk) begin
        if (cmd.ld_create) begin
            tag_mem[new_node] <= '0;
        end else if (cmd.ld_finish_ok) begin
            tag_mem[cursor_reg] <= {1'b1, IdW'(pats_reg)};
        end
        if (cmd.rd_tag) tag_rdata <= tag_mem[c_reg];
    end

    // Text ring buffer.
    always_ff @(posedge aclk) begin
        if (cmd.sc_append) buf_mem[base_reg + slen_reg] <= sym_reg;
        if (cmd.rd_buf) buf_rdata <= buf_mem[base_reg + j_reg];
    end

    // Control and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg     <= '0;
            ldepth_reg     <= '0;
            nodes_reg      <= NU_W'(1);
            pats_reg       <= '0;
            drop_reg       <= 1'b0;
            base_reg       <= '0;
            slen_reg       <= '0;
            pos_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.set_drop) drop_reg <= 1'b1;
            if (cmd.ld_step) begin
                cursor_reg <= c_reg;
                ldepth_reg <= ldepth_reg + LEN_W'(1);
            end
            if (cmd.ld_create) begin
                cursor_reg <= new_node;
                ldepth_reg <= ldepth_reg + LEN_W'(1);
                nodes_reg  <= nodes_reg + NU_W'(1);
            end
            if (cmd.ld_finish_ok) begin
                pats_reg   <= pats_reg + PAT_W'(1);
                cursor_reg <= '0;
                ldepth_reg <= '0;
            end
            if (cmd.ld_finish_drop) begin
                cursor_reg <= '0;
                ldepth_reg <= '0;
                drop_reg   <= 1'b0;
            end
            if (cmd.scan_clear) begin
                base_reg <= '0;
                slen_reg <= '0;
                pos_reg  <= '0;
            end
            if (cmd.sc_append) slen_reg <= slen_reg + BUF_AW'(1);
            if (cmd.commit) begin
                if (found_reg) begin
                    base_reg <= nbase_reg;
                    slen_reg <= nlen_reg;
                end else begin
                    slen_reg <= '0;
                end
                pos_reg <= pos_reg + POS_BITS'(1);
            end

            // Output register loads a result, or drains on a completed transaction.
            if (cmd.ld_finish_drop || ((cmd.push || cmd.flush) && hold_valid_reg)) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.push) hold_valid_reg <= 1'b1;
            if (cmd.flush && hold_valid_reg) hold_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= s_tuser;
            sym_reg  <= s_tdata;
            pend_reg <= s_tlast;
        end
        if (cmd.sc_append) begin
            i_reg     <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.walk_init) begin
            node_reg <= '0;
            j_reg    <= i_reg;
        end
        if (cmd.rd_goto && is_scan) byte_reg <= buf_rdata;
        if (cmd.rd_link) c_reg <= goto_rdata;
        if (cmd.sc_step) begin
            node_reg <= c_reg;
            j_reg    <= j_reg + BUF_AW'(1);
        end
        if (cmd.sc_hit && !found_reg) begin
            found_reg <= 1'b1;
            nbase_reg <= base_reg + i_reg;
            nlen_reg  <= match_len;
        end
        if (cmd.next_start) i_reg <= i_reg + BUF_AW'(1);

        // Result staging: the held match goes out once the next one or the end is known.
        if (cmd.ld_finish_drop) begin
            out_status_reg <= mpm_pkg::STATUS_DROP;
            out_id_reg     <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
        if (cmd.push) begin
            hold_id_reg  <= tag_rdata[IdW-1:0];
            hold_pos_reg <= OposW'(match_pos);
            if (hold_valid_reg) begin
                out_status_reg <= mpm_pkg::STATUS_MATCH;
                out_id_reg     <= hold_id_reg;
                out_pos_reg    <= hold_pos_reg;
                out_last_reg   <= 1'b0;
            end
        end
        if (cmd.flush && hold_valid_reg) begin
            out_status_reg <= mpm_pkg::STATUS_MATCH;
            out_id_reg     <= hold_id_reg;
            out_pos_reg    <= hold_pos_reg;
            out_last_reg   <= 1'b1;
        end
    end

    // Status back to the controller.
    always_comb begin
        st.func       = func_reg;
        st.pend       = pend_reg;
        st.dropping   = drop_reg;
        st.depth_full = (ldepth_reg == LEN_W'(MAX_PATTERN_LEN));
        st.nodes_full = (nodes_reg == NU_W'(MAX_NODES));
        st.pats_full  = (pats_reg == PAT_W'(MAX_PATTERNS));
        st.c_ok       = (c_reg != '0) && (NU_W'(c_reg) < nodes_reg)
                        && (link_rdata[NODE_W+7:8] == ref_node)
                        && (link_rdata[7:0] == ref_byte);
        st.j_last     = ((j_reg + BUF_AW'(1)) == slen_reg);
        st.i_done     = (i_reg == slen_reg);
        st.term       = tag_rdata[IdW];
        st.hold_valid = hold_valid_reg;
        st.out_free   = out_free;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_status_reg;
    assign m_tdata    = {out_pos_reg, out_id_reg};
    assign m_tlast    = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/multi_pattern_matcher.sv */
// Load item: goto, link and node check steps, skipped when its pattern is being dropped; a
// dropped end adds a step to hand its result to the output register, stalling while full.
// Reset-scan and unused items: dispatch only. Scan item: data dependent, steps per suffix
// start, per byte walked, on a full walk and per match, plus append, flush and output stalls.
// One item is worked at a time; each match goes through a hold and an output register.
// Reset (aresetn low, synchronous) clears all control state; no memory clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module multi_pattern_matcher #(
    parameter int MAX_NODES       = 1024,
    parameter int MAX_PATTERNS    = 256,
    parameter int MAX_PATTERN_LEN = 64,
    parameter int POS_BITS        = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // symbol[7:0]
    input  wire  [1:0]  s_tuser,   // func[1:0]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // pattern_id[7:0], start_pos[39:8]
    output logic [0:0]  m_tuser,   // status[0]
    output logic        m_tlast
);

    mpm_pkg::cmd_t    cmd;
    mpm_pkg::status_t st;

    // Sequencer.
    mpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Trie memories, scan buffer and result staging.
    mpm_datapath #(
        .MAX_NODES       (MAX_NODES),
        .MAX_PATTERNS    (MAX_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .POS_BITS        (POS_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int NODES   = 1024;
    localparam int PATS    = 256;
    localparam int PAT_LEN = 64;

    // Item kind the matcher ignores.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // One result as it leaves the matcher.
    typedef struct {
        logic       status;
        logic [7:0] pat_id;
        logic [31:0] start_pos;
        logic       last;
    } match_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = mpm_pkg::FUNC_RESET;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [39:0] m_tdata;
    wire  [0:0]  m_tuser;
    wire         m_tlast;

    int          errors = 0;
    int          hold_cycles = 0;
    bit          no_idle = 1'b0;
    match_t      pending_matches[$];

    // Trie shadow state.
    bit [10:0]   trie_child [0:NODES*256-1];
    int          node_parent [NODES];
    bit [7:0]    node_byte [NODES];
    bit          node_term [NODES];
    int          node_depth [NODES];
    bit [7:0]    node_pat [NODES];
    int          fail_memo [NODES];
    int          out_memo [NODES];
    int          fail_stamp [NODES];
    int          out_stamp [NODES];
    int          link_gen = 1;
    int          nodes_used = 1;
    int          pats_loaded = 0;
    int          load_node = 0;
    bit          dropping = 1'b0;
    int          scan_node = 0;
    logic [31:0] text_pos = '0;

    multi_pattern_matcher i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Failure link of a node, memoized until the trie changes.
    function automatic int fail_link(int n);
        int r;
        if (fail_stamp[n] == link_gen) return fail_memo[n];
        if (n == 0 || node_parent[n] == 0) r = 0;
        else r = goto_next(fail_link(node_parent[n]), node_byte[n]);
        fail_memo[n] = r;
        fail_stamp[n] = link_gen;
        return r;
    endfunction

    // Follow goto edges, falling back along failure links.
    function automatic int goto_next(int n, bit [7:0] sym);
        int c;
        while (1) begin
            c = trie_child[n*256 + sym];
            if (c != 0) return c;
            if (n == 0) return 0;
            n = fail_link(n);
        end
        return 0;
    endfunction

    // Nearest terminal node on the failure chain.
    function automatic int output_link(int n);
        int r;
        int f;
        if (out_stamp[n] == link_gen) return out_memo[n];
        if (n == 0 || node_parent[n] == 0) begin
            r = 0;
        end else begin
            f = fail_link(n);
            r = (f == 0 || node_term[f]) ? f : output_link(f);
        end
        out_memo[n] = r;
        out_stamp[n] = link_gen;
        return r;
    endfunction

    // Update the shadow trie for one accepted transaction and queue its results.
    function automatic void predict_matches(logic [1:0] func, bit [7:0] sym, bit pend);
        int c;
        int v;
        int k;
        match_t m;
        if (func == mpm_pkg::FUNC_LOAD) begin
            if (!dropping) begin
                c = trie_child[load_node*256 + sym];
                if (node_depth[load_node] >= PAT_LEN) begin
                    dropping = 1'b1;
                end else if (c == 0) begin
                    if (nodes_used >= NODES) begin
                        dropping = 1'b1;
                    end else begin
                        c = nodes_used++;
                        trie_child[load_node*256 + sym] = c;
                        node_parent[c] = load_node;
                        node_byte[c] = sym;
                        node_depth[c] = node_depth[load_node] + 1;
                        node_term[c] = 1'b0;
                        link_gen++;
                        load_node = c;
                    end
                end else begin
                    load_node = c;
                end
            end
            if (pend) begin
                if (dropping || pats_loaded >= PATS) begin
                    m.status = mpm_pkg::STATUS_DROP;
                    m.pat_id = '0;
                    m.start_pos = '0;
                    m.last = 1'b1;
                    pending_matches.insert(pending_matches.size(), m);
                end else begin
                    node_term[load_node] = 1'b1;
                    node_pat[load_node] = pats_loaded[7:0];
                    pats_loaded++;
                    link_gen++;
                end
                load_node = 0;
                dropping = 1'b0;
            end
        end else if (func == mpm_pkg::FUNC_RESET) begin
            scan_node = 0;
            text_pos = '0;
        end else if (func == mpm_pkg::FUNC_SCAN) begin
            scan_node = goto_next(scan_node, sym);
            v = scan_node;
            k = 0;
            while (v != 0 && k < PAT_LEN) begin
                if (node_term[v]) begin
                    if (k > 0) pending_matches[$].last = 1'b0;
                    m.status = mpm_pkg::STATUS_MATCH;
                    m.pat_id = node_pat[v];
                    m.start_pos = text_pos - node_depth[v] + 1;
                    m.last = 1'b1;
                    pending_matches.insert(pending_matches.size(), m);
                    k++;
                end
                v = output_link(v);
            end
            text_pos = text_pos + 1;
        end
    endfunction

    // Offer one transaction and hold it until the matcher takes it.
    task automatic send_item(logic [1:0] func, bit [7:0] sym, bit pend);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= sym;
        s_tlast <= pend;
        do @(negedge aclk); while (!s_tready);
        predict_matches(func, sym, pend);
        @(posedge aclk);
    endtask

    task automatic load_pattern(bit [7:0] bytes[$]);
        foreach (bytes[i]) send_item(mpm_pkg::FUNC_LOAD, bytes[i], i == bytes.size() - 1);
    endtask

    task automatic scan_text(bit [7:0] bytes[$]);
        foreach (bytes[i]) send_item(mpm_pkg::FUNC_SCAN, bytes[i], 1'b0);
    endtask

    // Receiver: random stalls, or a counted hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) < 70);
        end
    end

    // Compare each result with the oldest pending match.
    always @(negedge aclk) begin
        match_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matches.size() == 0) begin
                $error("unexpected result id=%0d pos=%0d", m_tdata[7:0], m_tdata[39:8]);
                errors++;
            end else begin
                want = pending_matches.pop_front();
                if (m_tuser[0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[7:0] !== want.pat_id) begin
                    $error("pattern_id: expected %0d, got %0d", want.pat_id, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[39:8] !== want.start_pos) begin
                    $error("start_pos: expected %0d, got %0d", want.start_pos,
                           m_tdata[39:8]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Classic overlapping patterns, byte extremes, reset scan and an unused code.
    task automatic test_directed();
        load_pattern('{8'h68, 8'h65});
        load_pattern('{8'h73, 8'h68, 8'h65});
        load_pattern('{8'h68, 8'h69, 8'h73});
        load_pattern('{8'h68, 8'h65, 8'h72, 8'h73});
        load_pattern('{8'h00});
        load_pattern('{8'hFF});
        load_pattern('{8'h68, 8'h65});
        scan_text('{8'h75, 8'h73, 8'h68, 8'h65, 8'h72, 8'h73, 8'hFF, 8'h00});
        send_item(mpm_pkg::FUNC_RESET, 8'h00, 1'b1);
        send_item(FUNC_SPARE, 8'hFF, 1'b1);
        scan_text('{8'h68, 8'h69, 8'h73});
    endtask

    // A pattern one byte deeper than allowed is dropped at its end.
    task automatic test_too_long();
        bit [7:0] bytes[$];
        for (int i = 0; i <= PAT_LEN; i++) bytes.insert(bytes.size(), 8'hA5 ^ i[7:0]);
        load_pattern(bytes);
        scan_text('{8'hA5, 8'hA4, 8'hA7});
    endtask

    // Random well-formed patterns and text over a small alphabet, plus noise.
    task automatic test_random();
        bit [7:0] bytes[$];
        int len;
        int sent;
        sent = 0;
        while (sent < 30) begin
            bytes.delete();
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                end else begin
                    bytes.insert(bytes.size(), 8'(8'h61 + $urandom_range(0, 3)));
                end
            end
            case ($urandom_range(0, 9))
                0, 1, 2: load_pattern(bytes);
                3: send_item(mpm_pkg::FUNC_RESET, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                4: send_item(FUNC_SPARE, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                default: scan_text(bytes);
            endcase
            sent += len;
            if (sent > 10 && sent < 20) no_idle = 1'b1;
            else no_idle = 1'b0;
        end
        no_idle = 1'b0;
    endtask

    // Long receiver hold-off while scan bytes with many matches keep coming.
    task automatic test_backpressure();
        load_pattern('{8'h61});
        load_pattern('{8'h61, 8'h61});
        load_pattern('{8'h61, 8'h61, 8'h61});
        @(posedge aclk);
        hold_cycles <= 400;
        for (int i = 0; i < 30; i++) send_item(mpm_pkg::FUNC_SCAN, 8'h61, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_too_long();
        test_random();
        test_backpressure();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
